// ===== design/vicl_pkg.sv =====
package vicl_pkg;

    localparam int VBUS_W    = 13;
    localparam int DUTY_W    = 7;
    localparam int LIMIT_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [DUTY_W-1:0]  DUTY_MAX       = 7'd100;
    localparam logic [DUTY_W-1:0]  START_DUTY_MAX = 7'd98;
    localparam logic [DUTY_W:0]    BEGIN_OFFSET   = 8'd90;
    localparam logic [DUTY_W:0]    OC_MARGIN      = 8'd15;
    localparam logic [DUTY_W-1:0]  STEP_DOWN      = 7'd3;
    localparam logic [DUTY_W:0]    STEP_UP        = 8'd5;
    localparam logic [DUTY_W-1:0]  LIGHT_DUTY     = 7'd84;
    localparam logic [LIMIT_W-1:0] MAP_A          = 12'd2958;
    localparam logic [LIMIT_W-1:0] MAP_B          = 12'd29;

    localparam logic [7:0]          OVERRIDE_RST       = 8'hFF;
    localparam logic [DUTY_W-1:0]   OC_FLOOR_RST       = 7'd0;
    localparam logic [VBUS_W-1:0]   VBUS_LOW_RST       = 13'd4500;
    localparam logic [VBUS_W-1:0]   VBUS_HARD_LOW_RST  = 13'd4400;
    localparam logic [VBUS_W-1:0]   VBUS_HIGH_RST      = 13'd4700;
    localparam logic [VBUS_W-1:0]   VBUS_HIGH_LIGHT_RST = 13'd4550;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_MANUAL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_PIN_LOW  = 2'd0,
        MODE_PIN_HIGH = 2'd1,
        MODE_PWM      = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_SET  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERRIDE        = 3'd0,
        CFG_OC_FLOOR        = 3'd1,
        CFG_VBUS_LOW        = 3'd2,
        CFG_VBUS_HARD_LOW   = 3'd3,
        CFG_VBUS_HIGH       = 3'd4,
        CFG_VBUS_HIGH_LIGHT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [7:0]   override_duty;
        logic [DUTY_W-1:0]   oc_floor;
        logic [VBUS_W-1:0]   vbus_low;
        logic [VBUS_W-1:0]   vbus_hard_low;
        logic [VBUS_W-1:0]   vbus_high;
        logic [VBUS_W-1:0]   vbus_high_light;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [VBUS_W-1:0]   vbus;
        logic                battery_neg;
        logic [DUTY_W-1:0]   nominal;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [DUTY_W-1:0]   nominal;
        mode_t               mode;
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [LIMIT_W-1:0]  limit_ma;
    } result_t;

endpackage

// ===== design/vicl_regs.sv =====
module vicl_regs
    import vicl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_OVERRIDE:        cfg_next.override_duty   = wr_data[7:0];
                CFG_OC_FLOOR:        cfg_next.oc_floor        = wr_data[DUTY_W-1:0];
                CFG_VBUS_LOW:        cfg_next.vbus_low        = wr_data;
                CFG_VBUS_HARD_LOW:   cfg_next.vbus_hard_low   = wr_data;
                CFG_VBUS_HIGH:       cfg_next.vbus_high       = wr_data;
                CFG_VBUS_HIGH_LIGHT: cfg_next.vbus_high_light = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.override_duty   <= OVERRIDE_RST;
            cfg_reg.oc_floor        <= OC_FLOOR_RST;
            cfg_reg.vbus_low        <= VBUS_LOW_RST;
            cfg_reg.vbus_hard_low   <= VBUS_HARD_LOW_RST;
            cfg_reg.vbus_high       <= VBUS_HIGH_RST;
            cfg_reg.vbus_high_light <= VBUS_HIGH_LIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/vicl_step.sv =====
module vicl_step
    import vicl_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic [DUTY_W:0]    start_sum;
    logic [DUTY_W-1:0]  start_duty;
    logic [DUTY_W-1:0]  target;
    logic [DUTY_W:0]    up_sum;
    logic [DUTY_W-1:0]  up_duty;
    logic [DUTY_W-1:0]  down_duty;
    logic [VBUS_W-1:0]  low_th;
    logic               vbus_low;
    logic               vbus_high;
    logic               down_ok;
    logic [LIMIT_W-1:0] prod;

    always_comb begin
        start_sum  = {1'b0, item.nominal} + BEGIN_OFFSET;
        start_duty = (start_sum > {1'b0, START_DUTY_MAX}) ? START_DUTY_MAX
                                                          : start_sum[DUTY_W-1:0];
        target     = (cfg.override_duty[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX
                                                                : cfg.override_duty[DUTY_W-1:0];
        up_sum     = {1'b0, state.duty} + STEP_UP;
        up_duty    = (up_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : up_sum[DUTY_W-1:0];
        down_duty  = (state.duty > STEP_DOWN) ? state.duty - STEP_DOWN : '0;
        low_th     = item.battery_neg ? cfg.vbus_hard_low : cfg.vbus_low;
        vbus_low   = (item.vbus < low_th) && (state.duty < DUTY_MAX);
        vbus_high  = (item.vbus > cfg.vbus_high) ||
                     ((item.vbus > cfg.vbus_high_light) && (state.duty > LIGHT_DUTY));
        // duty > nominal - 15, evaluated without going negative
        down_ok    = (({1'b0, state.duty} + OC_MARGIN) > {1'b0, state.nominal}) &&
                     (state.duty > cfg.oc_floor) && (state.duty != '0);
    end

    always_comb begin
        state_next    = state;
        result.action = ACT_NONE;
        unique case (item.op)
            OP_LOAD: begin
                state_next.nominal = item.nominal;
                state_next.duty    = start_duty;
                state_next.mode    = MODE_PWM;
                result.action      = ACT_SET;
            end
            OP_MANUAL: begin
                state_next.mode = MODE_PIN_HIGH;
            end
            OP_TICK: begin
                if (state.mode == MODE_PWM) begin
                    if (!cfg.override_duty[7]) begin
                        if (target != state.duty) begin
                            state_next.duty = target;
                            result.action   = ACT_SET;
                        end
                    end else if (vbus_low) begin
                        state_next.duty = up_duty;
                        result.action   = ACT_UP;
                    end else if (vbus_high && down_ok) begin
                        state_next.duty = down_duty;
                        result.action   = ACT_DOWN;
                    end
                end
            end
            default: begin
                state_next = state;
            end
        endcase
        prod            = MAP_B * {5'b0, state_next.duty};
        result.limit_ma = MAP_A - prod;
    end

endmodule

// ===== design/vbus_input_current_limit_loop_core.sv =====
// VBUS input current-limit loop. Each transaction on the s_ channel is a tick
// (regulate on VBUS and battery current), a load (store nominal duty, enter PWM)
// or a manual pin-high command (other codes change nothing), and yields exactly
// one result on the m_ channel with the new duty, pin mode, action taken and
// approximate current limit. Throughput is one transaction per clock unless
// m_ready stalls the output; each passes the input register, the combinational
// duty update and the result register. Configuration writes are taken every
// cycle (cfg_ready is always high) and must only be issued while the loop is idle.
module vbus_input_current_limit_loop_core
    import vicl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [VBUS_W-1:0]    s_vbus_mv,
    input  logic signed [15:0]   s_battery_ma,
    input  logic [DUTY_W-1:0]    s_nominal_duty,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DUTY_W-1:0]    m_duty_percent,
    output logic [1:0]           m_limit_mode,
    output logic [1:0]           m_action,
    output logic [LIMIT_W-1:0]   m_current_limit_ma,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t result;
    result_t result_reg;
    state_t  out_state_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    s_accept;
    logic    advance;

    assign cfg_ready = 1'b1;

    vicl_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vicl_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.duty    <= '0;
            state_reg.nominal <= '0;
            state_reg.mode    <= MODE_PIN_LOW;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.op          <= s_operation;
            item_reg.vbus        <= s_vbus_mv;
            item_reg.battery_neg <= s_battery_ma[15];
            item_reg.nominal     <= s_nominal_duty;
        end
        if (advance) begin
            result_reg    <= result;
            out_state_reg <= state_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_duty_percent     = out_state_reg.duty;
    assign m_limit_mode       = out_state_reg.mode;
    assign m_action           = result_reg.action;
    assign m_current_limit_ma = result_reg.limit_ma;

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.duty <= DUTY_MAX)
        else $error("duty state above 100");

    a_limit_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_current_limit_ma == MAP_A - MAP_B * {5'b0, m_duty_percent}))
        else $error("current limit does not match duty");

    a_set_in_pwm: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_action != ACT_NONE)) |-> (m_limit_mode == MODE_PWM))
        else $error("duty changed outside PWM mode");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline is full");

endmodule

// ===== sim/vbus_input_current_limit_loop_core_tb.sv =====
module vbus_input_current_limit_loop_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vicl_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BLOCKS = 9;
    localparam int ITEMS_PER_BLOCK = 155;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        mode_t              mode;
        action_t            action;
        logic [LIMIT_W-1:0] limit;
    } duty_report_t;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [1:0]           op;
        cfg_idx_t             reg_idx;
        logic [CFG_DAT_W-1:0] reg_data;
        logic [VBUS_W-1:0]    vbus;
        logic [15:0]          batt;
        logic [DUTY_W-1:0]    nom;
        logic [5:0]           reps;
        logic                 typed;
        duty_report_t         want;
    } stim_row_t;

    localparam duty_report_t NO_REPORT = '0;

    // Rows with typed = 1 carry their expected result; all others go through the predictor.
    localparam stim_row_t DIRECTED_SCRIPT [25] = '{
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd1, 1'b1,
          '{7'd0, MODE_PIN_LOW, ACT_NONE, 12'd2958}},
        '{ROW_ITEM, OP_RESERVED, CFG_OVERRIDE, 13'd0, 13'd8191, 16'h8000, 7'd127, 6'd1, 1'b1,
          '{7'd0, MODE_PIN_LOW, ACT_NONE, 12'd2958}},
        '{ROW_ITEM, OP_MANUAL, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd100, 6'd1, 1'b1,
          '{7'd0, MODE_PIN_HIGH, ACT_NONE, 12'd2958}},
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h8000, 7'd0, 6'd1, 1'b1,
          '{7'd0, MODE_PIN_HIGH, ACT_NONE, 12'd2958}},
        '{ROW_ITEM, OP_LOAD, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd1, 1'b1,
          '{7'd90, MODE_PWM, ACT_SET, 12'd348}},
        // step up twice, saturate at 100, then hold
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd3, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd8191, 16'h7FFF, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        // discharging: hard-low threshold applies
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd4450, 16'hFFFF, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd4450, 16'h0000, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        // light-load high threshold with duty above 84
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd4600, 16'h8000, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_LOAD, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd127, 6'd1, 1'b1,
          '{7'd98, MODE_PWM, ACT_SET, 12'd116}},
        // nominal margin blocks the step down
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd8191, 16'h0000, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_LOAD, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd5, 6'd1, 1'b1,
          '{7'd95, MODE_PWM, ACT_SET, 12'd203}},
        '{ROW_CFG, OP_TICK, CFG_OVERRIDE, 13'd5, 13'd0, 16'h0000, 7'd0, 6'd0, 1'b0,
          NO_REPORT},
        // override applies, then matches the duty
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd2, 1'b0,
          NO_REPORT},
        '{ROW_CFG, OP_TICK, CFG_OVERRIDE, 13'h0FF, 13'd0, 16'h0000, 7'd0, 6'd0, 1'b0,
          NO_REPORT},
        // step down clamps at zero, then stops
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd8191, 16'h0000, 7'd0, 6'd3, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_MANUAL, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd1, 1'b1,
          '{7'd0, MODE_PIN_HIGH, ACT_NONE, 12'd2958}},
        '{ROW_CFG, OP_TICK, CFG_OVERRIDE, 13'h07F, 13'd0, 16'h0000, 7'd0, 6'd0, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        '{ROW_ITEM, OP_LOAD, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd100, 6'd1, 1'b1,
          '{7'd98, MODE_PWM, ACT_SET, 12'd116}},
        // override above 100 saturates
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd0, 16'h0000, 7'd0, 6'd1, 1'b0,
          NO_REPORT},
        '{ROW_CFG, OP_TICK, CFG_OVERRIDE, 13'h080, 13'd0, 16'h0000, 7'd0, 6'd0, 1'b0,
          NO_REPORT},
        '{ROW_CFG, OP_TICK, CFG_OC_FLOOR, 13'd98, 13'd0, 16'h0000, 7'd0, 6'd0, 1'b0,
          NO_REPORT},
        // over-current floor stops the step down
        '{ROW_ITEM, OP_TICK, CFG_OVERRIDE, 13'd0, 13'd8191, 16'h0000, 7'd0, 6'd3, 1'b0,
          NO_REPORT}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_operation = '0;
    logic [VBUS_W-1:0]    s_vbus_mv = '0;
    logic signed [15:0]   s_battery_ma = '0;
    logic [DUTY_W-1:0]    s_nominal_duty = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DUTY_W-1:0]    m_duty_percent;
    logic [1:0]           m_limit_mode;
    logic [1:0]           m_action;
    logic [LIMIT_W-1:0]   m_current_limit_ma;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // predictor state and register copies
    logic [DUTY_W-1:0]  duty_st = '0;
    logic [DUTY_W-1:0]  nominal_st = '0;
    mode_t              mode_st = MODE_PIN_LOW;
    logic signed [7:0]  ovr_duty = OVERRIDE_RST;
    logic [DUTY_W-1:0]  oc_floor = OC_FLOOR_RST;
    logic [VBUS_W-1:0]  vbus_low = VBUS_LOW_RST;
    logic [VBUS_W-1:0]  vbus_hard_low = VBUS_HARD_LOW_RST;
    logic [VBUS_W-1:0]  vbus_high_th = VBUS_HIGH_RST;
    logic [VBUS_W-1:0]  vbus_light_th = VBUS_HIGH_LIGHT_RST;

    duty_report_t duty_reports_due[$];
    int mismatch_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 20;
    int sink_idle_pct = 45;

    vbus_input_current_limit_loop_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_vbus_mv         (s_vbus_mv),
        .s_battery_ma      (s_battery_ma),
        .s_nominal_duty    (s_nominal_duty),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_duty_percent    (m_duty_percent),
        .m_limit_mode      (m_limit_mode),
        .m_action          (m_action),
        .m_current_limit_ma(m_current_limit_ma),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #2ns aclk = 1'b1;
        #2ns aclk = 1'b0;
    end

    function automatic duty_report_t step_duty_loop(input logic [1:0] op,
                                                    input logic [VBUS_W-1:0] vbus,
                                                    input logic batt_neg,
                                                    input logic [DUTY_W-1:0] nom);
        duty_report_t rep;
        action_t act;
        logic [VBUS_W-1:0] low_th;
        logic vbus_is_high;
        int duty_calc;
        act = ACT_NONE;
        if (op == OP_LOAD) begin
            duty_calc = int'(nom) + int'(BEGIN_OFFSET);
            if (duty_calc > int'(START_DUTY_MAX))
                duty_calc = int'(START_DUTY_MAX);
            nominal_st = nom;
            duty_st = DUTY_W'(duty_calc);
            mode_st = MODE_PWM;
            act = ACT_SET;
        end else if (op == OP_MANUAL) begin
            mode_st = MODE_PIN_HIGH;
        end else if (op == OP_TICK && mode_st == MODE_PWM) begin
            if (ovr_duty >= 0) begin
                duty_calc = int'(ovr_duty);
                if (duty_calc > int'(DUTY_MAX))
                    duty_calc = int'(DUTY_MAX);
                if (duty_calc != int'(duty_st)) begin
                    duty_st = DUTY_W'(duty_calc);
                    act = ACT_SET;
                end
            end else begin
                low_th = batt_neg ? vbus_hard_low : vbus_low;
                if (vbus < low_th && duty_st < DUTY_MAX) begin
                    duty_calc = int'(duty_st) + int'(STEP_UP);
                    if (duty_calc > int'(DUTY_MAX))
                        duty_calc = int'(DUTY_MAX);
                    duty_st = DUTY_W'(duty_calc);
                    act = ACT_UP;
                end else begin
                    vbus_is_high = (vbus > vbus_high_th) ||
                                   (vbus > vbus_light_th && duty_st > LIGHT_DUTY);
                    // the nominal margin is a signed bound and may go negative
                    if (vbus_is_high && int'(duty_st) > int'(nominal_st) - int'(OC_MARGIN) &&
                        duty_st > oc_floor && duty_st != '0) begin
                        duty_st = (duty_st > STEP_DOWN) ? duty_st - STEP_DOWN : '0;
                        act = ACT_DOWN;
                    end
                end
            end
        end
        rep.duty = duty_st;
        rep.mode = mode_st;
        rep.action = act;
        rep.limit = LIMIT_W'(int'(MAP_A) - int'(MAP_B) * int'(duty_st));
        return rep;
    endfunction

    task automatic apply_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_OVERRIDE:        ovr_duty = data[7:0];
            CFG_OC_FLOOR:        oc_floor = data[DUTY_W-1:0];
            CFG_VBUS_LOW:        vbus_low = data[VBUS_W-1:0];
            CFG_VBUS_HARD_LOW:   vbus_hard_low = data[VBUS_W-1:0];
            CFG_VBUS_HIGH:       vbus_high_th = data[VBUS_W-1:0];
            CFG_VBUS_HIGH_LIGHT: vbus_light_th = data[VBUS_W-1:0];
            default: ;
        endcase
    endtask

    // Leaves cfg_valid high; the next item transaction drops it.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (duty_reports_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [VBUS_W-1:0] vbus,
                             input logic [15:0] batt, input logic [DUTY_W-1:0] nom,
                             input logic typed, input duty_report_t typed_rep);
        int gap;
        duty_report_t rep;
        cfg_valid <= 1'b0;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_vbus_mv <= vbus;
        s_battery_ma <= batt;
        s_nominal_duty <= nom;
        do @(posedge aclk); while (!s_ready);
        rep = step_duty_loop(op, vbus, batt[15], nom);
        duty_reports_due.push_back(typed ? typed_rep : rep);
    endtask

    task automatic send_random_item();
        int pick;
        int th;
        int v;
        logic [1:0] op;
        logic [VBUS_W-1:0] vbus;
        logic [15:0] batt;
        logic [DUTY_W-1:0] nom;
        pick = $urandom_range(0, 99);
        // outside PWM most ticks do nothing, so favor a load to re-enter regulation
        if (mode_st != MODE_PWM && $urandom_range(0, 2) == 0)
            op = OP_LOAD;
        else if (pick < 5)
            op = OP_LOAD;
        else if (pick < 9)
            op = OP_MANUAL;
        else if (pick < 12)
            op = OP_RESERVED;
        else
            op = OP_TICK;

        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            vbus = '0;
        end else if (pick == 1) begin
            vbus = '1;
        end else if (pick < 6) begin
            vbus = VBUS_W'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: th = int'(vbus_low);
                1: th = int'(vbus_hard_low);
                2: th = int'(vbus_high_th);
                default: th = int'(vbus_light_th);
            endcase
            v = th + int'($urandom_range(0, 24)) - 12;
            if (v < 0)
                v = 0;
            if (v > 8191)
                v = 8191;
            vbus = VBUS_W'(v);
        end

        pick = $urandom_range(0, 9);
        if (pick == 0)
            batt = 16'h0000;
        else if (pick == 1)
            batt = 16'h8000;
        else if (pick == 2)
            batt = 16'h7FFF;
        else if (pick == 3)
            batt = 16'hFFFF;
        else
            batt = 16'($urandom);

        if ($urandom_range(0, 9) == 0)
            nom = DUTY_W'($urandom_range(101, 127));
        else
            nom = DUTY_W'($urandom_range(0, 100));

        send_item(op, vbus, batt, nom, 1'b0, NO_REPORT);
    endtask

    task automatic configure_block(input int blk);
        logic [7:0] ovr;
        logic [DUTY_W-1:0] floor_val;
        logic [VBUS_W-1:0] th [4];
        th[0] = VBUS_LOW_RST;
        th[1] = VBUS_HARD_LOW_RST;
        th[2] = VBUS_HIGH_RST;
        th[3] = VBUS_HIGH_LIGHT_RST;
        case (blk)
            0: begin
                ovr = OVERRIDE_RST;
                floor_val = OC_FLOOR_RST;
            end
            1: begin
                ovr = 8'h80;
                floor_val = '0;
                for (int i = 0; i < 4; i++)
                    th[i] = '0;
            end
            2: begin
                ovr = 8'hFF;
                floor_val = '1;
                for (int i = 0; i < 4; i++)
                    th[i] = '1;
            end
            3: begin
                ovr = 8'($urandom_range(0, 127));
                floor_val = DUTY_W'($urandom_range(0, 40));
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    ovr = 8'($urandom_range(0, 127));
                else
                    ovr = 8'($urandom_range(128, 255));
                floor_val = DUTY_W'($urandom_range(0, 127));
                for (int i = 0; i < 4; i++) begin
                    if ($urandom_range(0, 1) == 0)
                        th[i] = VBUS_W'($urandom);
                    else
                        th[i] = VBUS_W'(int'(th[i]) + int'($urandom_range(0, 600)) - 300);
                end
            end
        endcase
        // unused upper data bits are randomized; the block must ignore them
        write_reg(CFG_OVERRIDE, {5'($urandom), ovr});
        write_reg(CFG_OC_FLOOR, {6'($urandom), floor_val});
        write_reg(CFG_VBUS_LOW, th[0]);
        write_reg(CFG_VBUS_HARD_LOW, th[1]);
        write_reg(CFG_VBUS_HIGH, th[2]);
        write_reg(CFG_VBUS_HIGH_LIGHT, th[3]);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        duty_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_reports_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result %0d with none pending: duty %0d mode %0d action %0d limit %0d",
                             results_seen, m_duty_percent, m_limit_mode, m_action,
                             m_current_limit_ma);
                mismatch_count++;
            end else begin
                want = duty_reports_due.pop_front();
                if (m_duty_percent !== want.duty || m_limit_mode !== want.mode ||
                    m_action !== want.action || m_current_limit_ma !== want.limit) begin
                    if (mismatch_count < 10)
                        $display({"result %0d mismatch: duty %0d/%0d mode %0d/%0d ",
                                  "action %0d/%0d limit %0d/%0d (expected/actual)"},
                                 results_seen, want.duty, m_duty_percent, want.mode,
                                 m_limit_mode, want.action, m_action, want.limit,
                                 m_current_limit_ma);
                    mismatch_count++;
                end
            end
            results_seen++;
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired with %0d results pending", duty_reports_due.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stim_row_t row;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_SCRIPT); i++) begin
            row = DIRECTED_SCRIPT[i];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                repeat (row.reps)
                    send_item(row.op, row.vbus, row.batt, row.nom, row.typed, row.want);
            end
        end

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            // swap idle pressure after a third of the blocks, then run without idling
            if (blk == 3) begin
                src_idle_pct = 45;
                sink_idle_pct = 20;
            end else if (blk == 6) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            wait_drained();
            configure_block(blk);
            for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                send_random_item();
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
